@@ rtl/core/prd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the pulse rate detector.
// No dependencies; every other file refers to this package by scoped names.
package prd_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 12;

  localparam int unsigned RATE_W     = 12;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned INTERVAL_W = 10;
  localparam int unsigned THRESH_W   = 12;
  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;

  // Rate in 1/16 BPM is floor(RATE_SCALE / period_ms)
  localparam int unsigned RATE_SCALE = 960000;
  localparam int unsigned RATE_DVD_W = 20;
  localparam logic [RATE_W-1:0] RATE_MAX = '1;

  // Baseline filter: new = floor((BASE_KEEP * old + raw) / BASE_DEN)
  localparam int unsigned BASE_KEEP = 99;
  localparam int unsigned BASE_DEN  = 100;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_INTERVAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PERIOD      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STALE           = 3'd4;

  localparam logic [INTERVAL_W-1:0] RST_SAMPLE_INTERVAL = 10'd20;
  localparam logic [THRESH_W-1:0]   RST_THRESHOLD       = 12'd30;
  localparam logic [PERIOD_W-1:0]   RST_MIN_PERIOD      = 16'd300;
  localparam logic [PERIOD_W-1:0]   RST_MAX_PERIOD      = 16'd2000;
  localparam logic [PERIOD_W-1:0]   RST_STALE           = 16'd8000;

  typedef struct packed {
    logic [INTERVAL_W-1:0] sample_interval;
    logic [THRESH_W-1:0]   threshold;
    logic [PERIOD_W-1:0]   min_period;
    logic [PERIOD_W-1:0]   max_period;
    logic [PERIOD_W-1:0]   stale;
  } prd_cfg_t;

  typedef struct packed {
    logic load_in;   // capture the input beat
    logic gate;      // interval check, start baseline sum
    logic mul;       // reciprocal multiply for the /100
    logic fix;       // correct quotient, update baseline
    logic crossing;  // ac level, crossing and period check
    logic commit;    // take divider result as new rate
    logic stale;     // clear rate when no beat for too long
    logic load_out;  // move result into the output register
  } prd_cmd_t;

  typedef struct packed {
    logic gated;       // sample arrived too early
    logic beat_start;  // rising crossing with period in bounds
    logic div_done;    // rate divider finished
  } prd_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GATE,
    ST_MUL,
    ST_FIX,
    ST_CROSS,
    ST_DIV,
    ST_STALE,
    ST_OUT
  } prd_state_e;

endpackage

@@ rtl/core/pulse_rate_detector.sv @@
`timescale 1ns / 1ps
// Pulse rate detector top level: configuration registers, controller and datapath.
// From accept to m_axis_tvalid a sample passes GATE and OUT if the interval gate drops
// it, else GATE, MUL, FIX, CROSS, STALE, OUT; a beat adds DIV for the 20-step rate divider.
// A new sample is accepted only after the last one is loaded for output; DIV is the worst case.
// Reset (rst_ni low, asynchronous): registers return to their defaults, baseline to
// mid-scale, timestamps and rate to zero, no result pending.
module pulse_rate_detector #(
  parameter int unsigned SAMPLE_BITS = prd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // tdata: raw_sample [SAMPLE_BITS-1:0], now_ms [SAMPLE_BITS+31:SAMPLE_BITS], zero pad
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [((SAMPLE_BITS+39)/8)*8-1:0]  s_axis_tdata,
  // tdata: rate_x16 [11:0], ac_level [SAMPLE_BITS+12:12], zero pad
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [((SAMPLE_BITS+20)/8)*8-1:0]  m_axis_tdata,
  // tuser: sample_taken [0], beat_seen [1]
  output logic [1:0]                         m_axis_tuser,
  input  logic                               cfg_we_i,
  input  logic [prd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [prd_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  localparam int unsigned SB      = SAMPLE_BITS;
  localparam int unsigned RW      = prd_pkg::RATE_W;
  localparam int unsigned OUT_W   = ((SB + 20) / 8) * 8;
  localparam int unsigned OUT_USE = RW + SB + 1;

  prd_pkg::prd_cfg_t    cfg_q;
  prd_pkg::prd_cmd_t    cmd;
  prd_pkg::prd_status_t status;
  logic [RW-1:0]        rate_x16;
  logic                 sample_taken;
  logic                 beat_seen;
  logic signed [SB:0]   ac_level;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_interval <= prd_pkg::RST_SAMPLE_INTERVAL;
      cfg_q.threshold       <= prd_pkg::RST_THRESHOLD;
      cfg_q.min_period      <= prd_pkg::RST_MIN_PERIOD;
      cfg_q.max_period      <= prd_pkg::RST_MAX_PERIOD;
      cfg_q.stale           <= prd_pkg::RST_STALE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        prd_pkg::CFG_SAMPLE_INTERVAL:
          cfg_q.sample_interval <= cfg_wdata_i[prd_pkg::INTERVAL_W-1:0];
        prd_pkg::CFG_THRESHOLD:  cfg_q.threshold  <= cfg_wdata_i[prd_pkg::THRESH_W-1:0];
        prd_pkg::CFG_MIN_PERIOD: cfg_q.min_period <= cfg_wdata_i;
        prd_pkg::CFG_MAX_PERIOD: cfg_q.max_period <= cfg_wdata_i;
        prd_pkg::CFG_STALE:      cfg_q.stale      <= cfg_wdata_i;
        default: ;  // drop writes past the last register
      endcase
    end
  end

  prd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  prd_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .cmd_i          (cmd),
    .status_o       (status),
    .raw_sample_i   (s_axis_tdata[SB-1:0]),
    .now_ms_i       (s_axis_tdata[SB+prd_pkg::TIME_W-1:SB]),
    .rate_x16_o     (rate_x16),
    .sample_taken_o (sample_taken),
    .beat_seen_o    (beat_seen),
    .ac_level_o     (ac_level)
  );

  assign m_axis_tdata = OUT_W'({ac_level, rate_x16});
  assign m_axis_tuser = {beat_seen, sample_taken};

  // A dropped sample carries no beat and a zero ac level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |->
      !m_axis_tuser[1] && (m_axis_tdata[OUT_USE-1:RW] == '0))
    else $error("dropped sample reports a beat or a nonzero ac level");

  // A beat always leaves a nonzero rate behind it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> (m_axis_tdata[RW-1:0] != '0))
    else $error("beat reported with zero rate");

  // Only one sample in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a sample is still in work");

endmodule

@@ rtl/core/prd_div.sv @@
`timescale 1ns / 1ps
// Restoring serial divider, one quotient bit per cycle, for the rate value.
// Depends on prd_pkg for the dividend and divisor widths.
module prd_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [prd_pkg::RATE_DVD_W-1:0]   dividend_i,
  input  logic [prd_pkg::PERIOD_W-1:0]     divisor_i,
  output logic                             done_o,
  output logic [prd_pkg::RATE_DVD_W-1:0]   quotient_o
);

  localparam int unsigned DW   = prd_pkg::RATE_DVD_W;
  localparam int unsigned VW   = prd_pkg::PERIOD_W;
  localparam int unsigned CNTW = $clog2(DW);
  localparam logic [CNTW-1:0] LAST_STEP = CNTW'(DW - 1);

  logic [VW-1:0]   rem_q, rem_d;
  logic [DW-1:0]   quo_q, quo_d;
  logic [VW-1:0]   dvs_q;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [VW:0]     shifted;
  logic [VW+1:0]   diff;

  assign shifted = {rem_q, quo_q[DW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // subtract when the shifted remainder covers the divisor
      if (!diff[VW+1]) begin
        rem_d = diff[VW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_d = shifted[VW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ rtl/core/prd_dp.sv @@
`timescale 1ns / 1ps
// Datapath: interval gate, baseline filter, crossing detector and rate state.
// Depends on prd_pkg and prd_div; steered by prd_ctrl through command bits.
module prd_dp #(
  parameter int unsigned SAMPLE_BITS = prd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  prd_pkg::prd_cfg_t             cfg_i,
  input  prd_pkg::prd_cmd_t             cmd_i,
  output prd_pkg::prd_status_t          status_o,
  input  logic [SAMPLE_BITS-1:0]        raw_sample_i,
  input  logic [prd_pkg::TIME_W-1:0]    now_ms_i,
  output logic [prd_pkg::RATE_W-1:0]    rate_x16_o,
  output logic                          sample_taken_o,
  output logic                          beat_seen_o,
  output logic signed [SAMPLE_BITS:0]   ac_level_o
);

  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned TW    = prd_pkg::TIME_W;
  localparam int unsigned RW    = prd_pkg::RATE_W;
  // 99 * baseline + raw stays below 100 * 2^SB < 2^(SB+7)
  localparam int unsigned SUM_W = SB + 7;
  localparam int unsigned RECIP_SHIFT = SUM_W + 7;
  localparam int unsigned RECIP_W     = RECIP_SHIFT - 6;
  localparam longint unsigned RECIP_L =
      (64'd1 << RECIP_SHIFT) / longint'(prd_pkg::BASE_DEN);
  localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'(RECIP_L);
  localparam logic [SUM_W-1:0]   KEEP      = SUM_W'(prd_pkg::BASE_KEEP);
  localparam logic [SUM_W-1:0]   DEN       = SUM_W'(prd_pkg::BASE_DEN);
  localparam int unsigned        PROD_W    = SUM_W + RECIP_W;
  localparam int unsigned        CMP_W     =
      ((SB > prd_pkg::THRESH_W) ? SB : prd_pkg::THRESH_W) + 2;
  localparam logic [SB-1:0]      BASE_RST  = SB'(1) << (SB - 1);
  localparam logic [prd_pkg::RATE_DVD_W-1:0] SCALE =
      prd_pkg::RATE_DVD_W'(prd_pkg::RATE_SCALE);

  // item and filter state
  logic [SB-1:0]        raw_q;
  logic [TW-1:0]        now_q;
  logic [SUM_W-1:0]     sum_q;
  logic [SB-1:0]        quo0_q;
  logic [SB-1:0]        baseline_q;
  logic [TW-1:0]        last_sample_q;
  logic                 was_above_q;
  logic [TW-1:0]        last_cross_q;
  logic [TW-1:0]        last_beat_q;
  logic [RW-1:0]        rate_q;
  logic                 taken_q;
  logic                 beat_q;
  logic signed [SB:0]   ac_q;

  // output register
  logic [RW-1:0]        out_rate_q;
  logic                 out_taken_q;
  logic                 out_beat_q;
  logic signed [SB:0]   out_ac_q;

  logic [TW-1:0]        since_sample;
  logic [TW-1:0]        period;
  logic [TW-1:0]        since_beat;
  logic [PROD_W-1:0]    prod;
  logic [SUM_W-1:0]     resid;
  logic [SB-1:0]        baseline_new;
  logic signed [SB:0]   ac_now;
  logic signed [CMP_W-1:0] ac_ext;
  logic signed [CMP_W-1:0] thr_ext;
  logic                 above;
  logic                 rising;
  logic                 in_bounds;
  logic                 div_start;
  logic [prd_pkg::RATE_DVD_W-1:0] quotient;
  logic [RW-1:0]        rate_sat;

  assign since_sample = now_q - last_sample_q;
  assign period       = now_q - last_cross_q;
  assign since_beat   = now_q - last_beat_q;

  assign prod  = PROD_W'(sum_q) * PROD_W'(RECIP);
  assign resid = sum_q - SUM_W'(quo0_q) * DEN;
  // reciprocal estimate is at most one low
  assign baseline_new = (resid >= DEN) ? quo0_q + 1'b1 : quo0_q;

  assign ac_now  = $signed({1'b0, raw_q}) - $signed({1'b0, baseline_q});
  assign ac_ext  = CMP_W'(ac_now);
  assign thr_ext = $signed(CMP_W'(cfg_i.threshold));
  assign above   = ac_ext > thr_ext;
  assign rising  = above && !was_above_q;
  assign in_bounds = (period > TW'(cfg_i.min_period)) && (period < TW'(cfg_i.max_period));
  assign div_start = cmd_i.crossing && rising && in_bounds;

  assign rate_sat = (|quotient[prd_pkg::RATE_DVD_W-1:RW]) ? prd_pkg::RATE_MAX
                                                          : quotient[RW-1:0];

  prd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (SCALE),
    .divisor_i  (period[prd_pkg::PERIOD_W-1:0]),
    .done_o     (status_o.div_done),
    .quotient_o (quotient)
  );

  assign status_o.gated      = since_sample < TW'(cfg_i.sample_interval);
  assign status_o.beat_start = rising && in_bounds;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      baseline_q    <= BASE_RST;
      last_sample_q <= '0;
      was_above_q   <= 1'b0;
      last_cross_q  <= '0;
      last_beat_q   <= '0;
      rate_q        <= '0;
    end else begin
      if (cmd_i.gate && !status_o.gated) begin
        last_sample_q <= now_q;
      end
      if (cmd_i.fix) begin
        baseline_q <= baseline_new;
      end
      if (cmd_i.crossing) begin
        was_above_q <= above;
        if (rising) begin
          last_cross_q <= now_q;
        end
      end
      if (cmd_i.commit) begin
        rate_q      <= rate_sat;
        last_beat_q <= now_q;
      end
      if (cmd_i.stale && (since_beat > TW'(cfg_i.stale))) begin
        rate_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      raw_q <= raw_sample_i;
      now_q <= now_ms_i;
    end
    if (cmd_i.gate) begin
      sum_q   <= SUM_W'(baseline_q) * KEEP + SUM_W'(raw_q);
      taken_q <= !status_o.gated;
      beat_q  <= 1'b0;
      ac_q    <= '0;
    end
    if (cmd_i.mul) begin
      quo0_q <= prod[RECIP_SHIFT +: SB];
    end
    if (cmd_i.crossing) begin
      ac_q <= ac_now;
    end
    if (cmd_i.commit) begin
      beat_q <= 1'b1;
    end
    if (cmd_i.load_out) begin
      out_rate_q  <= rate_q;
      out_taken_q <= taken_q;
      out_beat_q  <= beat_q;
      out_ac_q    <= ac_q;
    end
  end

  assign rate_x16_o     = out_rate_q;
  assign sample_taken_o = out_taken_q;
  assign beat_seen_o    = out_beat_q;
  assign ac_level_o     = out_ac_q;

endmodule

@@ rtl/core/prd_ctrl.sv @@
`timescale 1ns / 1ps
// Controller: sequences one sample through the datapath and owns both handshakes.
// Depends on prd_pkg for the state, command and status types.
module prd_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  prd_pkg::prd_status_t  status_i,
  output prd_pkg::prd_cmd_t     cmd_o
);

  prd_pkg::prd_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;
  logic                out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      prd_pkg::ST_IDLE:  if (in_valid_i) state_d = prd_pkg::ST_GATE;
      prd_pkg::ST_GATE:  state_d = status_i.gated ? prd_pkg::ST_OUT : prd_pkg::ST_MUL;
      prd_pkg::ST_MUL:   state_d = prd_pkg::ST_FIX;
      prd_pkg::ST_FIX:   state_d = prd_pkg::ST_CROSS;
      prd_pkg::ST_CROSS: begin
        state_d = status_i.beat_start ? prd_pkg::ST_DIV : prd_pkg::ST_STALE;
      end
      prd_pkg::ST_DIV:   if (status_i.div_done) state_d = prd_pkg::ST_STALE;
      prd_pkg::ST_STALE: state_d = prd_pkg::ST_OUT;
      prd_pkg::ST_OUT:   if (out_free) state_d = prd_pkg::ST_IDLE;
      default:           state_d = prd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      prd_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      prd_pkg::ST_GATE:  cmd_o.gate     = 1'b1;
      prd_pkg::ST_MUL:   cmd_o.mul      = 1'b1;
      prd_pkg::ST_FIX:   cmd_o.fix      = 1'b1;
      prd_pkg::ST_CROSS: cmd_o.crossing = 1'b1;
      prd_pkg::ST_DIV:   cmd_o.commit   = status_i.div_done;
      prd_pkg::ST_STALE: cmd_o.stale    = 1'b1;
      prd_pkg::ST_OUT:   cmd_o.load_out = out_free;
      default: ;
    endcase
  end

  // hold the result until the sink takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= prd_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
